/* hw/rtl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the hunk pool allocator
// widths, operation and status codes, queue and sequencer types
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_HUNKS = 1024;
    localparam int IDX_W     = $clog2(MAX_HUNKS);
    localparam int COUNT_W   = $clog2(MAX_HUNKS + 1);

    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 22;
    localparam int HUNK_W    = 13;
    localparam int POOL_W    = 11;
    localparam int STRIDE_W  = HUNK_W + 1;
    localparam int PROD_W    = IDX_W + STRIDE_W;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

    // register indexes
    localparam logic REG_HUNK_BYTES = 1'b0;
    localparam logic REG_POOL_HUNKS = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_CLEAR,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] hunk_index;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  capacity;
        logic [STRIDE_W-1:0] stride;
    } cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL
    } back_state_t;

endpackage

/* hw/rtl/fbpa_intf.sv */
// ----------------------------------------------------------------------------
// fbpa request and response channels
// valid/ready channels carrying allocator requests and responses
// ----------------------------------------------------------------------------
interface fbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbpa_pkg::OP_W-1:0]     operation;
    logic [fbpa_pkg::IDX_W-1:0]    hunk_index;

    modport source (output valid, output operation, output hunk_index, input ready);
    modport sink   (input valid, input operation, input hunk_index, output ready);
endinterface

interface fbpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbpa_pkg::STATUS_W-1:0] status;
    logic [fbpa_pkg::IDX_W-1:0]    out_index;
    logic [fbpa_pkg::OFFSET_W-1:0] out_offset;
    logic [fbpa_pkg::COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output out_index, output out_offset,
                    output free_count, input ready);
    modport sink   (input valid, input status, input out_index, input out_offset,
                    input free_count, output ready);
endinterface

/* hw/rtl/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size hunk allocator with lifo free stack
// allocate pops the free stack or bumps a fresh index; free pushes; reset
// empties the stack and rewinds the bump index
// ----------------------------------------------------------------------------
// Each request returns exactly one response carrying status, hunk index, byte
// offset (index times hunk_bytes rounded up to a multiple of 4, wrapped to
// 22 bits) and the free stack depth after the operation. Requests pass through
// a two-entry queue into a sequencer; an allocate served from the free stack
// steps through ram read, registered read data and offset multiply; every
// other request goes straight to the offset multiply, and the sequencer takes
// no new request until it is back in idle. A finished response waits in an
// output register, and the sequencer moves on to the next request while it is
// held; the multiply step waits while that register holds an untaken response.
// The free stack has no reset; only entries below the stack count are ever read.
// hunk_bytes at byte address 0 (reset 4), pool_hunks at address 4 (reset 1024,
// values below 2 act as 2, above 1024 act as 1024). Write only while idle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::ADDR_W-1:0]   paddr,
    input  logic [fbpa_pkg::DATA_W-1:0]   pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    fbpa_req_if.sink                      req,
    fbpa_rsp_if.source                    rsp
);

    logic [fbpa_pkg::HUNK_W-1:0]   hunk_bytes_reg;
    logic [fbpa_pkg::POOL_W-1:0]   pool_hunks_reg;
    logic                          cfg_write;
    logic                          reg_sel;
    fbpa_pkg::cfg_t                cfg;
    fbpa_pkg::cmd_t                cmd;
    logic                          cmd_valid;
    logic                          cmd_ready;

    // register index is the word address
    assign reg_sel   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunk_bytes_reg <= fbpa_pkg::HUNK_W'(4);
            pool_hunks_reg <= fbpa_pkg::POOL_W'(fbpa_pkg::MAX_HUNKS);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                fbpa_pkg::REG_HUNK_BYTES: hunk_bytes_reg <= pwdata[fbpa_pkg::HUNK_W-1:0];
                fbpa_pkg::REG_POOL_HUNKS: pool_hunks_reg <= pwdata[fbpa_pkg::POOL_W-1:0];
                default:                  hunk_bytes_reg <= hunk_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            fbpa_pkg::REG_HUNK_BYTES:
                prdata = fbpa_pkg::DATA_W'(hunk_bytes_reg);
            fbpa_pkg::REG_POOL_HUNKS:
                prdata = fbpa_pkg::DATA_W'(pool_hunks_reg);
            default:
                prdata = '0;
        endcase
    end

    // effective capacity, clamped to the supported pool range
    always_comb
    begin
        priority if (pool_hunks_reg < fbpa_pkg::POOL_W'(2))
        begin
            cfg.capacity = fbpa_pkg::COUNT_W'(2);
        end
        else if (pool_hunks_reg > fbpa_pkg::POOL_W'(fbpa_pkg::MAX_HUNKS))
        begin
            cfg.capacity = fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_HUNKS);
        end
        else
        begin
            cfg.capacity = fbpa_pkg::COUNT_W'(pool_hunks_reg);
        end
    end

    // hunk length rounded up to a multiple of four
    assign cfg.stride = ({1'b0, hunk_bytes_reg} + fbpa_pkg::STRIDE_W'(3))
                      & ~fbpa_pkg::STRIDE_W'(3);

    fbpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fbpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg       (cfg),
        .rsp       (rsp)
    );

endmodule

/* hw/rtl/fbpa_ram.sv */
// ----------------------------------------------------------------------------
// fbpa_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/fbpa_front.sv */
// ----------------------------------------------------------------------------
// fbpa_front: request intake
// decodes the operation field and holds requests in a two-entry queue
// ----------------------------------------------------------------------------
module fbpa_front (
    input  logic             clk,
    input  logic             rst_n,
    fbpa_req_if.sink         req,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output fbpa_pkg::cmd_t   cmd
);

    fbpa_pkg::cmd_t                   entry_reg [fbpa_pkg::QUEUE_DEPTH];
    logic [fbpa_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [fbpa_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [fbpa_pkg::QCNT_W-1:0]      count_reg, count_next;
    fbpa_pkg::cmd_t                   decoded;
    logic                             push, pop;

    // classify the operation code
    always_comb
    begin
        decoded.hunk_index = req.hunk_index;
        unique case (req.operation)
            fbpa_pkg::OP_ALLOC: decoded.kind = fbpa_pkg::CMD_ALLOC;
            fbpa_pkg::OP_FREE:  decoded.kind = fbpa_pkg::CMD_FREE;
            fbpa_pkg::OP_RESET: decoded.kind = fbpa_pkg::CMD_CLEAR;
            default:            decoded.kind = fbpa_pkg::CMD_BAD;
        endcase
    end

    assign req.ready = (count_reg != fbpa_pkg::QCNT_W'(fbpa_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

/* hw/rtl/fbpa_back.sv */
// ----------------------------------------------------------------------------
// fbpa_back: allocator execution
// free stack in ram, bump index, offset multiply and response register
// ----------------------------------------------------------------------------
module fbpa_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  fbpa_pkg::cmd_t   cmd,
    input  fbpa_pkg::cfg_t   cfg,
    fbpa_rsp_if.source       rsp
);

    fbpa_pkg::back_state_t             state_reg, state_next;
    logic [fbpa_pkg::COUNT_W-1:0]      stack_count_reg, stack_count_next;
    logic [fbpa_pkg::COUNT_W-1:0]      bump_reg, bump_next;
    logic [fbpa_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [fbpa_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [fbpa_pkg::COUNT_W-1:0]      cnt_res_reg, cnt_res_next;

    logic                              out_valid_reg, out_valid_next;
    logic [fbpa_pkg::STATUS_W-1:0]     out_status_reg;
    logic [fbpa_pkg::IDX_W-1:0]        out_index_reg;
    logic [fbpa_pkg::OFFSET_W-1:0]     out_offset_reg;
    logic [fbpa_pkg::COUNT_W-1:0]      out_count_reg;

    logic                              ram_we, ram_re;
    logic [fbpa_pkg::IDX_W-1:0]        ram_waddr, ram_raddr, ram_rdata;
    logic [fbpa_pkg::PROD_W-1:0]       product;
    logic                              load_out;
    logic [fbpa_pkg::COUNT_W-1:0]      count_minus_one;

    fbpa_ram #(
        .WIDTH (fbpa_pkg::IDX_W),
        .DEPTH (fbpa_pkg::MAX_HUNKS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.hunk_index),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_minus_one = stack_count_reg - 1'b1;
    assign ram_waddr       = stack_count_reg[fbpa_pkg::IDX_W-1:0];
    assign ram_raddr       = count_minus_one[fbpa_pkg::IDX_W-1:0];
    assign cmd_ready       = (state_reg == fbpa_pkg::S_IDLE);

    assign product = {{fbpa_pkg::STRIDE_W{1'b0}}, idx_reg}
                   * {{fbpa_pkg::IDX_W{1'b0}}, cfg.stride};

    always_comb
    begin
        state_next       = state_reg;
        stack_count_next = stack_count_reg;
        bump_next        = bump_reg;
        idx_next         = idx_reg;
        status_next      = status_reg;
        cnt_res_next     = cnt_res_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        load_out         = 1'b0;

        unique case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    idx_next    = '0;
                    status_next = fbpa_pkg::ST_OK;
                    state_next  = fbpa_pkg::S_MUL;
                    unique case (cmd.kind)
                        fbpa_pkg::CMD_ALLOC:
                        begin
                            priority if (stack_count_reg != '0)
                            begin
                                // pop most recently freed hunk
                                ram_re           = 1'b1;
                                stack_count_next = count_minus_one;
                                state_next       = fbpa_pkg::S_READ;
                            end
                            else if (bump_reg < cfg.capacity)
                            begin
                                idx_next  = bump_reg[fbpa_pkg::IDX_W-1:0];
                                bump_next = bump_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = fbpa_pkg::ST_EXHAUSTED;
                            end
                        end
                        fbpa_pkg::CMD_FREE:
                        begin
                            if ({1'b0, cmd.hunk_index} >= bump_reg
                                || stack_count_reg
                                   >= fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_HUNKS))
                            begin
                                status_next = fbpa_pkg::ST_INVALID;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                stack_count_next = stack_count_reg + 1'b1;
                            end
                        end
                        fbpa_pkg::CMD_CLEAR:
                        begin
                            stack_count_next = '0;
                            bump_next        = '0;
                        end
                        default:
                        begin
                            status_next = fbpa_pkg::ST_INVALID;
                        end
                    endcase
                    cnt_res_next = stack_count_next;
                end
            end
            fbpa_pkg::S_READ:
            begin
                idx_next   = ram_rdata;
                state_next = fbpa_pkg::S_MUL;
            end
            fbpa_pkg::S_MUL:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = fbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fbpa_pkg::S_IDLE;
            stack_count_reg <= '0;
            bump_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stack_count_reg <= stack_count_next;
            bump_reg        <= bump_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        cnt_res_reg <= cnt_res_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_index_reg  <= idx_reg;
            out_offset_reg <= product[fbpa_pkg::OFFSET_W-1:0];
            out_count_reg  <= cnt_res_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.out_index  = out_index_reg;
    assign rsp.out_offset = out_offset_reg;
    assign rsp.free_count = out_count_reg;

    // stack never holds more than the largest pool
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_HUNKS))
        else $error("free stack count out of range");

    // bump index never passes the largest pool
    a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_HUNKS))
        else $error("bump index out of range");

    // a stack pop always proceeds to the multiply step
    a_read_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbpa_pkg::S_READ |=> state_reg == fbpa_pkg::S_MUL)
        else $error("stack read not followed by multiply");

    // a new request is taken only in idle and always moves the back end out of it
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> state_reg != fbpa_pkg::S_IDLE)
        else $error("request taken without leaving idle");

endmodule
